// File: rtl/core/imt_pkg.sv
package imt_pkg;

    localparam int CAPACITY   = 32;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 8;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int TOT_BITS   = CNT_BITS + 1;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] STAT_LOOKUP  = 2'd0;
    localparam logic [1:0] STAT_APPLIED = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_REBUILD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic decide;
        logic rebuild_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rebuild_go;
        logic rebuild_done;
    } stat_t;

endpackage

// File: rtl/core/imt_if.sv
interface imt_in_if;
    import imt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [KEY_BITS-1:0] range_begin;
    logic signed [KEY_BITS-1:0] range_end;
    logic [VALUE_BITS-1:0]      new_value;
    logic signed [KEY_BITS-1:0] query_key;

    modport source (output valid, operation, range_begin, range_end, new_value, query_key,
                    input ready);
    modport sink   (input valid, operation, range_begin, range_end, new_value, query_key,
                    output ready);
endinterface

interface imt_out_if;
    import imt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] found_value;
    logic [1:0]            status;

    modport source (output valid, found_value, status, input ready);
    modport sink   (input valid, found_value, status, output ready);
endinterface

// File: rtl/core/imt_ctrl.sv
module imt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  imt_pkg::stat_t stat,
    output imt_pkg::cmd_t  cmd
);
    import imt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_SCAN;
            ST_SCAN:    if (stat.scan_done) state_next = ST_DECIDE;
            ST_DECIDE:  state_next = stat.rebuild_go ? ST_REBUILD : ST_FIN;
            ST_REBUILD: if (stat.rebuild_done) state_next = ST_FIN;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd              = '0;
        in_ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:    cmd.scan_step    = !stat.scan_done;
            ST_DECIDE:  cmd.decide       = 1'b1;
            ST_REBUILD: cmd.rebuild_step = !stat.rebuild_done;
            ST_FIN:     cmd.finish       = out_free;
            default:    cmd              = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !out_ready) |=> (state_reg == ST_FIN))
        else $error("result overwritten before taken");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input taken while busy");
    a_rebuild_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_REBUILD) |-> $past(state_reg == ST_DECIDE))
        else $error("rebuild entered without decision");

endmodule

// File: rtl/core/imt_dp.sv
module imt_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [imt_pkg::VALUE_BITS-1:0]          cfg_wr_data,
    input  logic                                    operation,
    input  logic signed [imt_pkg::KEY_BITS-1:0]     range_begin,
    input  logic signed [imt_pkg::KEY_BITS-1:0]     range_end,
    input  logic [imt_pkg::VALUE_BITS-1:0]          new_value,
    input  logic signed [imt_pkg::KEY_BITS-1:0]     query_key,
    output logic [imt_pkg::VALUE_BITS-1:0]          found_value,
    output logic [1:0]                              status,
    input  imt_pkg::cmd_t                           cmd,
    output imt_pkg::stat_t                          stat
);
    import imt_pkg::*;

    logic [KEY_BITS-1:0]   keys_reg [CAPACITY];
    logic [KEY_BITS-1:0]   keys_next [CAPACITY];
    logic [VALUE_BITS-1:0] vals_reg [CAPACITY];
    logic [VALUE_BITS-1:0] vals_next [CAPACITY];
    logic [CNT_BITS-1:0]   occ_reg, occ_next;
    logic [VALUE_BITS-1:0] default_reg;

    logic                       op_reg;
    logic signed [KEY_BITS-1:0] b_reg, e_reg;
    logic [VALUE_BITS-1:0]      v_reg, before_reg, at_end_reg;
    logic [CNT_BITS-1:0]        cnt_reg, j_reg, lo_reg, hi_reg;
    logic                       ins_b_reg, ins_e_reg;
    logic [VALUE_BITS-1:0]      found_reg;
    logic [1:0]                 res_status_reg;

    logic signed [KEY_BITS-1:0] scan_key;
    logic [VALUE_BITS-1:0]      scan_val;
    logic                       empty, full, need_b, need_e;
    logic [TOT_BITS-1:0]        total;
    logic [1:0]                 decided;

    logic                  do_ins, pop, keep, push;
    logic [KEY_BITS-1:0]   push_key;
    logic [VALUE_BITS-1:0] push_val;
    logic [CNT_BITS-1:0]   widx_full;
    logic [IDX_BITS-1:0]   widx;

    assign scan_key = $signed(keys_reg[j_reg[IDX_BITS-1:0]]);
    assign scan_val = vals_reg[j_reg[IDX_BITS-1:0]];

    assign empty  = (b_reg >= e_reg);
    assign need_b = (v_reg != before_reg);
    assign need_e = (at_end_reg != v_reg);
    assign total  = TOT_BITS'(lo_reg) + TOT_BITS'(need_b) + TOT_BITS'(need_e)
                  + TOT_BITS'(cnt_reg) - TOT_BITS'(hi_reg);
    assign full   = (total > TOT_BITS'(CAPACITY));

    always_comb
    begin
        priority if (op_reg == OP_LOOKUP) decided = STAT_LOOKUP;
        else if (empty)                   decided = STAT_EMPTY;
        else if (full)                    decided = STAT_FULL;
        else                              decided = STAT_APPLIED;
    end

    assign stat.scan_done    = (j_reg == cnt_reg);
    assign stat.rebuild_go   = (decided == STAT_APPLIED);
    assign stat.rebuild_done = (j_reg == cnt_reg) && !ins_b_reg && !ins_e_reg;

    // new range goes in once the overwritten entries are gone, so the line never overfills
    assign do_ins    = (j_reg == hi_reg) && (ins_b_reg || ins_e_reg);
    assign pop       = !do_ins && (j_reg < cnt_reg);
    assign keep      = pop && ((j_reg < lo_reg) || (j_reg >= hi_reg));
    assign push      = cmd.rebuild_step && (do_ins || keep);
    assign push_key  = do_ins ? (ins_b_reg ? b_reg : e_reg) : keys_reg[0];
    assign push_val  = do_ins ? (ins_b_reg ? v_reg : at_end_reg) : vals_reg[0];
    assign widx_full = pop ? occ_reg - CNT_BITS'(1) : occ_reg;
    assign widx      = widx_full[IDX_BITS-1:0];

    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            keys_next[i] = keys_reg[i];
            vals_next[i] = vals_reg[i];
        end
        if (cmd.rebuild_step)
        begin
            if (pop)
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    keys_next[i] = keys_reg[i+1];
                    vals_next[i] = vals_reg[i+1];
                end
            end
            if (push)
            begin
                keys_next[widx] = push_key;
                vals_next[widx] = push_val;
            end
            occ_next = occ_reg - CNT_BITS'(pop) + CNT_BITS'(push);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keys_reg[i] <= keys_next[i];
            vals_reg[i] <= vals_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            default_reg <= '0;
            cnt_reg     <= '0;
            j_reg       <= '0;
            ins_b_reg   <= 1'b0;
            ins_e_reg   <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cfg_wr_en)
                default_reg <= cfg_wr_data;
            if (cmd.load)
            begin
                cnt_reg <= occ_reg;
                j_reg   <= '0;
            end
            if (cmd.scan_step)
                j_reg <= j_reg + CNT_BITS'(1);
            if (cmd.decide)
            begin
                j_reg     <= '0;
                ins_b_reg <= need_b;
                ins_e_reg <= need_e;
            end
            if (cmd.rebuild_step)
            begin
                if (do_ins)
                begin
                    if (ins_b_reg)
                        ins_b_reg <= 1'b0;
                    else
                        ins_e_reg <= 1'b0;
                end
                if (pop)
                    j_reg <= j_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            b_reg      <= range_begin;
            e_reg      <= (operation == OP_LOOKUP) ? query_key : range_end;
            v_reg      <= new_value;
            lo_reg     <= '0;
            hi_reg     <= '0;
            before_reg <= default_reg;
            at_end_reg <= default_reg;
        end
        if (cmd.scan_step)
        begin
            if (scan_key < b_reg)
            begin
                lo_reg     <= j_reg + CNT_BITS'(1);
                before_reg <= scan_val;
            end
            if (scan_key <= e_reg)
            begin
                hi_reg     <= j_reg + CNT_BITS'(1);
                at_end_reg <= scan_val;
            end
        end
        if (cmd.decide)
        begin
            res_status_reg <= decided;
            found_reg      <= (op_reg == OP_LOOKUP) ? at_end_reg : '0;
        end
        if (cmd.finish)
        begin
            found_value <= found_reg;
            status      <= res_status_reg;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_BITS'(CAPACITY))
        else $error("table overfilled");
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        j_reg <= cnt_reg)
        else $error("walk index past entry count");
    a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |=> $stable(occ_reg))
        else $error("table changed during scan");
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (occ_reg < CNT_BITS'(CAPACITY)))
        else $error("insert into full line");

endmodule

// File: rtl/core/interval_range_map_table_core.sv
// channel | dir | beat fields
// in_ch   | in  | operation, range_begin, range_end, new_value, query_key
// out_ch  | out | found_value, status
// cfg     | in  | cfg_wr_en, cfg_wr_data (default value)
//
// One item at a time. A lookup makes one pass over the table's entries and an applied
// assign makes two: one pass walks the table, a second rotates it through its shift line
// dropping the overwritten entries and inserting the new ones.
// rst_n empties the table at once; no clearing pass.
// A waiting result sits in the output register; the next beat is taken meanwhile.
module interval_range_map_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [imt_pkg::VALUE_BITS-1:0] cfg_wr_data,
    imt_in_if.sink                         in_ch,
    imt_out_if.source                      out_ch
);
    import imt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    imt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    imt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (in_ch.operation),
        .range_begin (in_ch.range_begin),
        .range_end   (in_ch.range_end),
        .new_value   (in_ch.new_value),
        .query_key   (in_ch.query_key),
        .found_value (out_ch.found_value),
        .status      (out_ch.status),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
